FILE: rtl/signed_int_to_decimal_ascii_top_assert.svh
// Assertion macros shared by the converter blocks.
// Each expects clk and rst_n in scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

`define SIDA_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sida assertion failed");

`define SIDA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sida assertion failed");

`endif

FILE: rtl/sida_pkg.sv
package sida_pkg;

    localparam int WORD_W      = 32;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = 10;
    localparam int BCD_W       = DIGIT_W * NUM_DIGITS;
    localparam int CHAR_W      = 8;
    localparam int SHIFT_CNT_W = $clog2(WORD_W);
    localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);

    localparam logic [SHIFT_CNT_W-1:0] SHIFT_LAST    = SHIFT_CNT_W'(WORD_W - 1);
    localparam logic [DIGIT_CNT_W-1:0] DIGIT_CNT_ALL = DIGIT_CNT_W'(NUM_DIGITS);
    localparam logic [DIGIT_CNT_W-1:0] DIGIT_CNT_ONE = DIGIT_CNT_W'(1);

    localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = DIGIT_W'(3);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } sida_word_t;

endpackage

FILE: rtl/sida_conv.sv
`include "signed_int_to_decimal_ascii_top_assert.svh"

module sida_conv
    import sida_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [WORD_W-1:0] in_value,
    output logic              out_valid,
    input  logic              out_ready,
    output sida_word_t        out_word
);

    typedef enum logic [2:0] {
        CV_IDLE = 3'b001,
        CV_RUN  = 3'b010,
        CV_DONE = 3'b100
    } sida_conv_state_t;

    sida_conv_state_t         state_reg, state_next;
    logic [WORD_W-1:0]        mag_reg, mag_next;
    logic [BCD_W-1:0]         bcd_reg, bcd_next;
    logic [SHIFT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                     neg_reg, neg_next;
    logic [BCD_W-1:0]         bcd_adj;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= BCD_ADJ_MIN)
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + BCD_ADJ_ADD;
            end
            else
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        case (state_reg)
            CV_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = in_value[WORD_W-1];
                    mag_next   = in_value[WORD_W-1] ? (~in_value + WORD_W'(1)) : in_value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = CV_RUN;
                end
            end
            CV_RUN:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[WORD_W-1]};
                mag_next = {mag_reg[WORD_W-2:0], 1'b0};
                cnt_next = cnt_reg + SHIFT_CNT_W'(1);
                if (cnt_reg == SHIFT_LAST)
                begin
                    state_next = CV_DONE;
                end
            end
            CV_DONE:
            begin
                if (out_ready)
                begin
                    state_next = CV_IDLE;
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign in_ready     = (state_reg == CV_IDLE);
    assign out_valid    = (state_reg == CV_DONE);
    assign out_word.neg = neg_reg;
    assign out_word.bcd = bcd_reg;

    `SIDA_ASSERT_NEXT(a_conv_take_starts, in_valid && in_ready, state_reg == CV_RUN && cnt_reg == '0)
    `SIDA_ASSERT_NEXT(a_conv_last_shift_done, state_reg == CV_RUN && cnt_reg == SHIFT_LAST, state_reg == CV_DONE)
    `SIDA_ASSERT_NEXT(a_conv_word_held, out_valid && !out_ready, out_valid && $stable(out_word))

endmodule

FILE: rtl/sida_emit.sv
`include "signed_int_to_decimal_ascii_top_assert.svh"

module sida_emit
    import sida_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sida_word_t        in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SIGN = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } sida_emit_state_t;

    sida_emit_state_t         state_reg, state_next;
    logic [BCD_W-1:0]         bcd_reg, bcd_next;
    logic [DIGIT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                     valid_reg, valid_next;
    logic [CHAR_W-1:0]        char_reg, char_next;
    logic                     last_reg, last_next;
    logic [DIGIT_W-1:0]       top_digit;
    logic                     slot_free;
    logic                     emit_go;
    logic [CHAR_W-1:0]        emit_char;
    logic                     emit_last;

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        emit_go    = 1'b0;
        emit_char  = CHAR_ZERO;
        emit_last  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    bcd_next   = in_word.bcd;
                    cnt_next   = DIGIT_CNT_ALL;
                    state_next = in_word.neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    emit_go    = 1'b1;
                    emit_char  = CHAR_MINUS;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (top_digit == '0 && cnt_reg != DIGIT_CNT_ONE)
                begin
                    bcd_next = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    cnt_next = cnt_reg - DIGIT_CNT_ONE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    emit_go   = 1'b1;
                    emit_char = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
                    emit_last = (cnt_reg == DIGIT_CNT_ONE);
                    bcd_next  = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    cnt_next  = cnt_reg - DIGIT_CNT_ONE;
                    if (cnt_reg == DIGIT_CNT_ONE)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (emit_go)
        begin
            valid_next = 1'b1;
            char_next  = emit_char;
            last_next  = emit_last;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    `SIDA_ASSERT_SAME(a_emit_digits_left, state_reg == ST_EMIT || state_reg == ST_SKIP, cnt_reg != '0)
    `SIDA_ASSERT_NEXT(a_emit_last_ends, emit_go && emit_last, state_reg == ST_IDLE && last_reg)
    `SIDA_ASSERT_NEXT(a_emit_shows_word, emit_go, valid_reg && char_reg == $past(emit_char))

endmodule

FILE: rtl/signed_int_to_decimal_ascii_top.sv
// Signed 32-bit integer to decimal ASCII text. Each accepted value comes out as its characters,
// most significant first: a minus sign for negative values, no leading zeros, a single '0' for
// zero, and last_char set on the final character. A value is converted by a double-dabble shift
// register that takes one magnitude bit per cycle: the converter loads the value, shifts in all 32
// magnitude bits and then holds the result for hand-over; a new value is accepted once the previous
// one has been handed to the character stage. The character stage then strips leading zeros and
// sends characters while the next value converts.
module signed_int_to_decimal_ascii_top
    import sida_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [WORD_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [CHAR_W-1:0]        char_code,
    output logic                     last_char
);

    logic       word_valid;
    logic       word_ready;
    sida_word_t word;

    sida_conv u_conv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_value  (value),
        .out_valid (word_valid),
        .out_ready (word_ready),
        .out_word  (word)
    );

    sida_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (word_valid),
        .in_ready  (word_ready),
        .in_word   (word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (char_code),
        .out_last  (last_char)
    );

endmodule
